FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL of the compression unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked on clk, off while rst is high.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on clk, off while rst is high.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sha1bc_pkg.sv
// Types, constants and round helpers of the block compression unit.
package sha1bc_pkg;

  localparam int CHAIN_WORDS     = 5;
  localparam int BLOCK_WORDS     = 16;
  localparam int ROUNDS_PER_PHASE = 20;
  localparam int NUM_PHASES      = 4;

  localparam int CNT_W   = $clog2(BLOCK_WORDS);
  localparam int SUB_W   = $clog2(ROUNDS_PER_PHASE);
  localparam int PHASE_W = $clog2(NUM_PHASES);
  localparam int IDX_W   = $clog2(CHAIN_WORDS);

  // Configuration register indexes
  localparam logic [1:0] CFG_K0 = 2'd0;
  localparam logic [1:0] CFG_K1 = 2'd1;
  localparam logic [1:0] CFG_K2 = 2'd2;
  localparam logic [1:0] CFG_K3 = 2'd3;

  // Input operation codes
  localparam logic OP_MSG  = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Round phases, twenty rounds each
  localparam logic [PHASE_W-1:0] PHASE_CH   = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_PAR1 = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_MAJ  = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_PAR2 = 2'd3;

  localparam logic [31:0] K_RESET [NUM_PHASES] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [31:0] H_INIT [CHAIN_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ROUND = 3'b010,
    S_FINAL = 3'b100
  } state_t;

  function automatic logic [31:0] rol5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rol30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

  function automatic logic [31:0] rol1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  // Choose, parity or majority by phase
  function automatic logic [31:0] round_fn(input logic [PHASE_W-1:0] phase,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
    logic [31:0] f;
    case (phase)
      PHASE_CH:   f = (b & c) | (~b & d);
      PHASE_PAR1: f = b ^ c ^ d;
      PHASE_MAJ:  f = (b & c) | (b & d) | (c & d);
      PHASE_PAR2: f = b ^ c ^ d;
      default:    f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

FILE: rtl/sha1_block_compress_unit.sv
// SHA-1 compression unit: message shift line, one shared round unit, final adder.
// Load and message items are accepted whenever busy is low. The sixteenth message
// word raises busy for 80 rounds through one round adder, then five chaining-word
// additions through one 32-bit adder; the five results appear one per cycle after
// the rounds. Results cannot be stalled. Reset loads the initial hash and standard
// constants, word count zero.
`include "assert_macros.svh"

module sha1_block_compress_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] data,
  input  logic [2:0]  chain_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [31:0] digest_word,
  output logic [2:0]  digest_index,
  output logic        last
);

  sha1bc_pkg::state_t state;

  logic [31:0] k_reg [sha1bc_pkg::NUM_PHASES];
  logic [31:0] cv    [sha1bc_pkg::CHAIN_WORDS];
  logic [31:0] sched [sha1bc_pkg::BLOCK_WORDS];

  logic [sha1bc_pkg::CNT_W-1:0]   word_count;
  logic [sha1bc_pkg::PHASE_W-1:0] phase;
  logic [sha1bc_pkg::SUB_W-1:0]   sub_cnt;
  logic [sha1bc_pkg::IDX_W-1:0]   fin_cnt;

  logic [31:0] a, b, c, d, e;

  logic        accept;
  logic        last_word;
  logic        last_round;
  logic        blk_go;
  logic        in_round;
  logic        in_final;
  logic [31:0] w_next;
  logic [31:0] round_sum;
  logic [31:0] final_sum;

  assign busy      = (state != sha1bc_pkg::S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign last_word = (word_count == sha1bc_pkg::CNT_W'(sha1bc_pkg::BLOCK_WORDS - 1));
  assign last_round = (phase == sha1bc_pkg::PHASE_PAR2) &&
                      (sub_cnt == sha1bc_pkg::SUB_W'(sha1bc_pkg::ROUNDS_PER_PHASE - 1));
  assign blk_go    = accept && (op == sha1bc_pkg::OP_MSG) && last_word;
  assign in_round  = (state == sha1bc_pkg::S_ROUND);
  assign in_final  = (state == sha1bc_pkg::S_FINAL);

  // Shared round datapath and schedule expansion
  assign w_next    = sha1bc_pkg::rol1(sched[13] ^ sched[8] ^ sched[2] ^ sched[0]);
  assign round_sum = sha1bc_pkg::rol5(a) + sha1bc_pkg::round_fn(phase, b, c, d)
                     + e + sched[0] + k_reg[phase];

  // Shared final adder, one chaining word a cycle
  assign final_sum = cv[0] + a;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sha1bc_pkg::NUM_PHASES; i++) begin
        k_reg[i] <= sha1bc_pkg::K_RESET[i];
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sha1bc_pkg::CFG_K0: k_reg[0] <= cfg_data;
        sha1bc_pkg::CFG_K1: k_reg[1] <= cfg_data;
        sha1bc_pkg::CFG_K2: k_reg[2] <= cfg_data;
        sha1bc_pkg::CFG_K3: k_reg[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Message shift line: fill on message items, advance once per round
  always_ff @(posedge clk) begin
    if (accept && op == sha1bc_pkg::OP_MSG) begin
      for (int i = 0; i < sha1bc_pkg::BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[sha1bc_pkg::BLOCK_WORDS - 1] <= data;
    end else if (state == sha1bc_pkg::S_ROUND) begin
      for (int i = 0; i < sha1bc_pkg::BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[sha1bc_pkg::BLOCK_WORDS - 1] <= w_next;
    end
  end

  // Sequencer, chaining value and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sha1bc_pkg::S_IDLE;
      word_count <= '0;
      phase      <= '0;
      sub_cnt    <= '0;
      fin_cnt    <= '0;
      for (int i = 0; i < sha1bc_pkg::CHAIN_WORDS; i++) begin
        cv[i] <= sha1bc_pkg::H_INIT[i];
      end
    end else begin
      case (state)
        sha1bc_pkg::S_IDLE: begin
          if (accept) begin
            if (op == sha1bc_pkg::OP_LOAD) begin
              if (chain_index < 3'(sha1bc_pkg::CHAIN_WORDS)) begin
                cv[chain_index] <= data;
              end
            end else begin
              word_count <= word_count + sha1bc_pkg::CNT_W'(1);
              if (last_word) begin
                state   <= sha1bc_pkg::S_ROUND;
                phase   <= '0;
                sub_cnt <= '0;
              end
            end
          end
        end
        sha1bc_pkg::S_ROUND: begin
          if (sub_cnt == sha1bc_pkg::SUB_W'(sha1bc_pkg::ROUNDS_PER_PHASE - 1)) begin
            sub_cnt <= '0;
            phase   <= phase + sha1bc_pkg::PHASE_W'(1);
          end else begin
            sub_cnt <= sub_cnt + sha1bc_pkg::SUB_W'(1);
          end
          if (last_round) begin
            state   <= sha1bc_pkg::S_FINAL;
            fin_cnt <= '0;
          end
        end
        sha1bc_pkg::S_FINAL: begin
          // Rotate the chaining words through the adder
          for (int i = 0; i < sha1bc_pkg::CHAIN_WORDS - 1; i++) begin
            cv[i] <= cv[i + 1];
          end
          cv[sha1bc_pkg::CHAIN_WORDS - 1] <= final_sum;
          fin_cnt <= fin_cnt + sha1bc_pkg::IDX_W'(1);
          if (fin_cnt == sha1bc_pkg::IDX_W'(sha1bc_pkg::CHAIN_WORDS - 1)) begin
            state <= sha1bc_pkg::S_IDLE;
          end
        end
        default: state <= sha1bc_pkg::S_IDLE;
      endcase
    end
  end

  // Working words: seed, run rounds, drain through the final adder
  always_ff @(posedge clk) begin
    if (blk_go) begin
      a <= cv[0];
      b <= cv[1];
      c <= cv[2];
      d <= cv[3];
      e <= cv[4];
    end else if (state == sha1bc_pkg::S_ROUND) begin
      a <= round_sum;
      b <= a;
      c <= sha1bc_pkg::rol30(b);
      d <= c;
      e <= d;
    end else if (state == sha1bc_pkg::S_FINAL) begin
      a <= b;
      b <= c;
      c <= d;
      d <= e;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == sha1bc_pkg::S_FINAL);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == sha1bc_pkg::S_FINAL) begin
      digest_word  <= final_sum;
      digest_index <= 3'(fin_cnt);
      last         <= (fin_cnt == sha1bc_pkg::IDX_W'(sha1bc_pkg::CHAIN_WORDS - 1));
    end
  end

  `ASSERT_NEXT(a_enter_final, in_round && last_round, in_final, "rounds did not reach final add")
  `ASSERT_NEXT(a_busy_cause, !busy && !blk_go, !busy, "busy rose without a sixteenth word")
  `ASSERT_NEXT(a_count_wrap, blk_go, word_count == '0 && in_round, "word count did not wrap")
  `ASSERT_NEXT(a_single_run, done && last, !done, "result strobe ran past the last word")
  `ASSERT_NOW(a_fin_range, in_final, fin_cnt < 3'(sha1bc_pkg::CHAIN_WORDS), "final count out of range")

endmodule

FILE: tb/tb.sv
// Testbench for the SHA-1 block compression unit: queued item driver, digest monitor, predictor.
module tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 120;

  typedef struct {
    logic        op;
    logic [31:0] data;
    logic [2:0]  idx;
    int          gap;
  } item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        op = 1'b0;
  logic [31:0] data = '0;
  logic [2:0]  chain_index = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = sha1bc_pkg::CFG_K0;
  logic [31:0] cfg_data = '0;
  logic        done;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        last;

  sha1_block_compress_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .data(data), .chain_index(chain_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .digest_word(digest_word), .digest_index(digest_index), .last(last)
  );

  // Predictor state
  logic [31:0] chain_val [sha1bc_pkg::CHAIN_WORDS];
  logic [31:0] msg_words [sha1bc_pkg::BLOCK_WORDS];
  logic [3:0]  word_cnt;
  logic [31:0] round_k [4];

  item_t   item_q [$];
  digest_t digest_q [$];
  item_t   cur_item;
  int      gap_left = 0;
  bit      took;
  int      errors = 0;
  int      cycles = 0;
  int      n_msg = 0, n_load = 0, n_ignored = 0, n_digests = 0, n_settings = 1;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void reset_model();
    chain_val[0] = 32'h67452301;
    chain_val[1] = 32'hEFCDAB89;
    chain_val[2] = 32'h98BADCFE;
    chain_val[3] = 32'h10325476;
    chain_val[4] = 32'hC3D2E1F0;
    round_k[sha1bc_pkg::CFG_K0] = 32'h5A827999;
    round_k[sha1bc_pkg::CFG_K1] = 32'h6ED9EBA1;
    round_k[sha1bc_pkg::CFG_K2] = 32'h8F1BBCDC;
    round_k[sha1bc_pkg::CFG_K3] = 32'hCA62C1D6;
    word_cnt = '0;
  endfunction

  // Expand the schedule, run eighty rounds, fold the working words into the chain
  function automatic void compress_words();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < sha1bc_pkg::BLOCK_WORDS; i++) w[i] = msg_words[i];
    for (int i = sha1bc_pkg::BLOCK_WORDS; i < 80; i++)
      w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_val[0];
    b = chain_val[1];
    c = chain_val[2];
    d = chain_val[3];
    e = chain_val[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = round_k[sha1bc_pkg::CFG_K0];
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = round_k[sha1bc_pkg::CFG_K1];
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = round_k[sha1bc_pkg::CFG_K2];
      end else begin
        f = b ^ c ^ d;
        k = round_k[sha1bc_pkg::CFG_K3];
      end
      t = rotl(a, 5) + f + e + w[i] + k;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_val[0] = chain_val[0] + a;
    chain_val[1] = chain_val[1] + b;
    chain_val[2] = chain_val[2] + c;
    chain_val[3] = chain_val[3] + d;
    chain_val[4] = chain_val[4] + e;
  endfunction

  // Apply one accepted item; queue the five digest words after a full block
  function automatic void apply_item(input item_t it);
    digest_t dg;
    if (it.op == sha1bc_pkg::OP_LOAD) begin
      if (it.idx < sha1bc_pkg::CHAIN_WORDS) begin
        chain_val[it.idx] = it.data;
        n_load++;
      end else begin
        n_ignored++;
      end
    end else begin
      n_msg++;
      msg_words[word_cnt] = it.data;
      word_cnt = word_cnt + 4'd1;
      if (word_cnt == 4'd0) begin
        compress_words();
        for (int k = 0; k < sha1bc_pkg::CHAIN_WORDS; k++) begin
          dg.word  = chain_val[k];
          dg.index = 3'(k);
          dg.last  = (k == sha1bc_pkg::CHAIN_WORDS - 1);
          digest_q.push_back(dg);
        end
      end
    end
  endfunction

  function automatic item_t mk_item(input logic o, input logic [31:0] v, input logic [2:0] ix,
                                    input bit calm);
    item_t it;
    it.op   = o;
    it.data = v;
    it.idx  = ix;
    it.gap  = calm ? 0 : $urandom_range(0, 8);
    return it;
  endfunction

  // Mostly message words with random content, some chain loads, a few bad indexes
  function automatic item_t rand_item(input bit calm);
    int          r;
    int          sel;
    logic [31:0] v;
    r   = $urandom_range(0, 99);
    sel = $urandom_range(0, 7);
    v   = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
    if (r < 8) return mk_item(sha1bc_pkg::OP_LOAD, v, 3'($urandom_range(0, 4)), calm);
    if (r < 11) return mk_item(sha1bc_pkg::OP_LOAD, v, 3'($urandom_range(5, 7)), calm);
    return mk_item(sha1bc_pkg::OP_MSG, v, 3'($urandom_range(0, 7)), calm);
  endfunction

  // Queue random items; ignored loads do not count toward the total
  task automatic queue_random(input int count);
    int    j;
    item_t it;
    j = 0;
    while (j < count) begin
      it = rand_item(((j / 30) % 3) == 1);
      item_q.push_back(it);
      if (!(it.op == sha1bc_pkg::OP_LOAD && it.idx >= sha1bc_pkg::CHAIN_WORDS)) j++;
    end
  endtask

  // Hold until every item is taken and every digest word has come, then let it settle
  task automatic wait_idle();
    while (item_q.size() > 0 || start || gap_left > 0 || digest_q.size() > 0 || busy)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four round constants back to back; call at a rising edge
  task automatic set_consts(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
    logic [1:0]  regs [4];
    logic [31:0] vals [4];
    regs[0] = sha1bc_pkg::CFG_K0;
    regs[1] = sha1bc_pkg::CFG_K1;
    regs[2] = sha1bc_pkg::CFG_K2;
    regs[3] = sha1bc_pkg::CFG_K3;
    vals[0] = k0; vals[1] = k1; vals[2] = k2; vals[3] = k3;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      round_k[regs[i]] = vals[i];
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Driver: present the next queued item after its gap, hold it until taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      took = start && !busy;
      if (took) apply_item(cur_item);
      if (!start || took) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (item_q.size() > 0) begin
          cur_item = item_q.pop_front();
          op          <= cur_item.op;
          data        <= cur_item.data;
          chain_index <= cur_item.idx;
          start       <= 1'b1;
          gap_left    = cur_item.gap;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed digest word with the oldest expected one
  always @(posedge clk) begin
    if (!rst && done) begin
      n_digests++;
      if (digest_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest word: expected none, actual %h index %0d last %b",
                 $time, digest_word, digest_index, last);
      end else begin
        if (digest_word !== digest_q[0].word) begin
          errors++;
          $display("%0t: digest_word mismatch: expected %h, actual %h",
                   $time, digest_q[0].word, digest_word);
        end
        if (digest_index !== digest_q[0].index) begin
          errors++;
          $display("%0t: digest_index mismatch: expected %0d, actual %0d",
                   $time, digest_q[0].index, digest_index);
        end
        if (last !== digest_q[0].last) begin
          errors++;
          $display("%0t: last mismatch: expected %b, actual %b",
                   $time, digest_q[0].last, last);
        end
        void'(digest_q.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d digest words still expected",
               cycles, digest_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: bad chain indexes, extreme chain words, a load in mid-block
    item_q.push_back(mk_item(sha1bc_pkg::OP_LOAD, 32'hFFFF_FFFF, 3'd7, 1'b0));
    item_q.push_back(mk_item(sha1bc_pkg::OP_LOAD, 32'h0000_0000, 3'd5, 1'b0));
    item_q.push_back(mk_item(sha1bc_pkg::OP_LOAD, 32'hFFFF_FFFF, 3'd0, 1'b0));
    item_q.push_back(mk_item(sha1bc_pkg::OP_LOAD, 32'h0000_0000, 3'd4, 1'b0));
    for (int i = 0; i < sha1bc_pkg::BLOCK_WORDS; i++) begin
      if (i == 8) item_q.push_back(mk_item(sha1bc_pkg::OP_LOAD, 32'h0F0F_0F0F, 3'd2, 1'b0));
      item_q.push_back(mk_item(sha1bc_pkg::OP_MSG,
                               (i % 3 == 0) ? 32'hFFFF_FFFF :
                               (i % 3 == 1) ? 32'h0000_0000 : 32'h8000_0001,
                               3'(i), 1'b0));
    end
    queue_random(110);
    wait_idle();

    // Sweep the round constants through their extremes, a random setting and the standard values
    set_consts(32'h0, 32'h0, 32'h0, 32'h0);
    queue_random(90);
    wait_idle();
    set_consts(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(90);
    wait_idle();
    set_consts($urandom, $urandom, $urandom, $urandom);
    queue_random(100);
    wait_idle();
    set_consts(32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6);
    queue_random(90);
    wait_idle();

    $display("Covered %0d message words, %0d chain loads, %0d ignored loads",
             n_msg, n_load, n_ignored);
    $display("Checked %0d digest words over %0d round-constant settings, %0d errors",
             n_digests, n_settings, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
